// ----- design/dersig_pkg.sv -----
// Shared types and constants for the DER signature to raw r||s converter.
// No dependencies; used by the channel interfaces and the top level.
package dersig_pkg;

    typedef logic [7:0] byte_t;

    localparam byte_t SEQ_TAG  = 8'h30;
    localparam byte_t INT_TAG  = 8'h02;
    localparam int    MIN_SIG_BYTES = 8;

    // parser phases
    localparam logic [2:0] PH_SEQ_TAG = 3'd0;
    localparam logic [2:0] PH_SEQ_LEN = 3'd1;
    localparam logic [2:0] PH_INT_TAG = 3'd2;
    localparam logic [2:0] PH_INT_LEN = 3'd3;
    localparam logic [2:0] PH_INT_VAL = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

endpackage

// ----- design/dersig_in_if.sv -----
// Input channel: one DER signature byte per item, flag on the final byte.
// Depends on dersig_pkg.
interface dersig_in_if;
    logic               valid;
    logic               ready;
    dersig_pkg::byte_t  sig_byte;
    logic               final_byte;

    modport source (output valid, output sig_byte, output final_byte, input ready);
    modport sink   (input valid, input sig_byte, input final_byte, output ready);
endinterface

// ----- design/dersig_out_if.sv -----
// Output channel: one raw r||s byte per item with status and last flag.
// Depends on dersig_pkg.
interface dersig_out_if;
    logic               valid;
    logic               ready;
    logic               ok;
    dersig_pkg::byte_t  rs_byte;
    logic               last_out;

    modport source (output valid, output ok, output rs_byte, output last_out, input ready);
    modport sink   (input valid, input ok, input rs_byte, input last_out, output ready);
endinterface

// ----- design/der_ecdsa_signature_to_raw_rs.sv -----
// DER ECDSA signature parser producing raw r||s bytes.
// Takes one byte per cycle unless stalled; each result leaves through output registers.
// A good signature yields 2*COORD_BYTES items, one per cycle while rs_out is ready, an error one item.
// Two store banks: parsing fills one while the other drains; input stalls only
// when the bank to be filled next still holds a signature not yet fully drained.
// Reset (rst_n low, async) empties both banks and restarts the parser.
module der_ecdsa_signature_to_raw_rs #(
    parameter int COORD_BYTES   = 32,
    parameter int MAX_SIG_BYTES = 72
) (
    input  logic                clk,
    input  logic                rst_n,
    dersig_in_if.sink           sig_in,
    dersig_out_if.source        rs_out
);

    localparam int RS_BYTES = 2 * COORD_BYTES;
    localparam int PW       = $clog2(RS_BYTES);
    localparam int LW       = $clog2(COORD_BYTES + 2);
    localparam int BW       = $clog2(MAX_SIG_BYTES + 2);

    // parser state
    logic [2:0]     phase_reg, phase_next;
    logic [BW-1:0]  bc_reg, bc_next;
    logic [7:0]     seq_reg, seq_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [LW-1:0]  idx_reg, idx_next;
    logic           dos_reg, dos_next;
    logic           fvz_reg, fvz_next;   // first value byte was zero
    logic           err_reg, err_next;
    logic           wr_en;
    logic [PW-1:0]  wr_pos;
    logic [LW:0]    psum;
    logic [LW:0]    pdiff;
    logic           good;

    // banks
    logic                       pb_reg;      // bank being filled
    logic                       db_reg;      // bank being drained
    logic [1:0]                 busy_reg;
    logic [1:0]                 okb_reg;
    logic [1:0][RS_BYTES-1:0]   vld_reg;
    dersig_pkg::byte_t          mem [2][RS_BYTES];

    // drain / output
    logic [PW-1:0]      cnt_reg;
    logic               out_valid_reg;
    logic               ok_out_reg;
    logic               last_reg;
    logic               vbit_reg;
    dersig_pkg::byte_t  rdata_reg;
    logic               advance;
    logic               issue;
    logic               finish;
    logic               in_acc;
    dersig_pkg::byte_t  b;

    assign b      = sig_in.sig_byte;
    assign in_acc = sig_in.valid && sig_in.ready;
    assign sig_in.ready = !busy_reg[pb_reg];

    assign psum  = (LW+1)'(idx_reg) + (LW+1)'(COORD_BYTES);
    assign pdiff = psum - (LW+1)'(len_reg);

    always_comb
    begin
        phase_next = phase_reg;
        seq_next   = seq_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        dos_next   = dos_reg;
        fvz_next   = fvz_reg;
        err_next   = err_reg;
        wr_en      = 1'b0;
        wr_pos     = PW'(pdiff) + (dos_reg ? PW'(COORD_BYTES) : PW'(0));
        bc_next    = (bc_reg <= BW'(MAX_SIG_BYTES)) ? bc_reg + BW'(1) : bc_reg;
        if (!err_reg)
        begin
            case (phase_reg)
                dersig_pkg::PH_SEQ_TAG:
                begin
                    if (b != dersig_pkg::SEQ_TAG) err_next = 1'b1;
                    else phase_next = dersig_pkg::PH_SEQ_LEN;
                end
                dersig_pkg::PH_SEQ_LEN:
                begin
                    seq_next   = b;
                    phase_next = dersig_pkg::PH_INT_TAG;
                end
                dersig_pkg::PH_INT_TAG:
                begin
                    if (b != dersig_pkg::INT_TAG) err_next = 1'b1;
                    else phase_next = dersig_pkg::PH_INT_LEN;
                end
                dersig_pkg::PH_INT_LEN:
                begin
                    if (b == 8'd0 || b > 8'(COORD_BYTES + 1))
                        err_next = 1'b1;
                    else
                    begin
                        len_next   = LW'(b);
                        idx_next   = '0;
                        phase_next = dersig_pkg::PH_INT_VAL;
                    end
                end
                dersig_pkg::PH_INT_VAL:
                begin
                    if (idx_reg == LW'(0))
                    begin
                        if (b[7]) err_next = 1'b1;
                        if (len_reg == LW'(COORD_BYTES + 1) && b != 8'd0) err_next = 1'b1;
                        fvz_next = (b == 8'd0);
                    end
                    else if (idx_reg == LW'(1))
                    begin
                        // redundant leading zero
                        if (fvz_reg && !b[7]) err_next = 1'b1;
                    end
                    if (!err_next)
                    begin
                        wr_en    = (psum >= (LW+1)'(len_reg));
                        idx_next = idx_reg + LW'(1);
                        if (idx_next >= len_reg)
                        begin
                            if (dos_reg) phase_next = dersig_pkg::PH_DONE;
                            else
                            begin
                                dos_next   = 1'b1;
                                phase_next = dersig_pkg::PH_INT_TAG;
                            end
                        end
                    end
                end
                default: err_next = 1'b1;
            endcase
        end
    end

    assign good = !err_next && phase_next == dersig_pkg::PH_DONE &&
                  bc_next >= BW'(dersig_pkg::MIN_SIG_BYTES) &&
                  bc_next <= BW'(MAX_SIG_BYTES) &&
                  {1'b0, seq_next} == 9'(bc_next) - 9'd2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dersig_pkg::PH_SEQ_TAG;
            bc_reg    <= '0;
            seq_reg   <= '0;
            len_reg   <= '0;
            idx_reg   <= '0;
            dos_reg   <= 1'b0;
            fvz_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end
        else if (in_acc)
        begin
            if (sig_in.final_byte)
            begin
                phase_reg <= dersig_pkg::PH_SEQ_TAG;
                bc_reg    <= '0;
                seq_reg   <= '0;
                len_reg   <= '0;
                idx_reg   <= '0;
                dos_reg   <= 1'b0;
                fvz_reg   <= 1'b0;
                err_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                bc_reg    <= bc_next;
                seq_reg   <= seq_next;
                len_reg   <= len_next;
                idx_reg   <= idx_next;
                dos_reg   <= dos_next;
                fvz_reg   <= fvz_next;
                err_reg   <= err_next;
            end
        end
    end

    // drain side: rdata_reg doubles as the output register
    assign advance = !out_valid_reg || rs_out.ready;
    assign issue   = advance && busy_reg[db_reg];
    assign finish  = issue && (!okb_reg[db_reg] || cnt_reg == PW'(RS_BYTES - 1));

    always_ff @(posedge clk)
    begin
        if (in_acc && wr_en)
            mem[pb_reg][wr_pos] <= b;
        if (issue)
            rdata_reg <= mem[db_reg][cnt_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pb_reg        <= 1'b0;
            db_reg        <= 1'b0;
            busy_reg      <= '0;
            okb_reg       <= '0;
            vld_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            ok_out_reg    <= 1'b0;
            last_reg      <= 1'b0;
            vbit_reg      <= 1'b0;
        end
        else
        begin
            if (in_acc && wr_en)
                vld_reg[pb_reg][wr_pos] <= 1'b1;
            if (in_acc && sig_in.final_byte)
            begin
                busy_reg[pb_reg] <= 1'b1;
                okb_reg[pb_reg]  <= good;
                pb_reg           <= !pb_reg;
            end
            if (advance)
                out_valid_reg <= busy_reg[db_reg];
            if (issue)
            begin
                ok_out_reg <= okb_reg[db_reg];
                last_reg   <= finish;
                vbit_reg   <= vld_reg[db_reg][cnt_reg];
                cnt_reg    <= finish ? '0 : cnt_reg + PW'(1);
            end
            if (finish)
            begin
                // bank goes back to the parser empty
                busy_reg[db_reg] <= 1'b0;
                vld_reg[db_reg]  <= '0;
                db_reg           <= !db_reg;
            end
        end
    end

    assign rs_out.valid    = out_valid_reg;
    assign rs_out.ok       = ok_out_reg;
    assign rs_out.rs_byte  = (ok_out_reg && vbit_reg) ? rdata_reg : '0;
    assign rs_out.last_out = last_reg;

endmodule
